// ===== src/irn_pkg.sv =====
// shared types, letter codes and the microcode table for the roman numeral converter
// no dependencies
`default_nettype none
package irn_pkg;

	localparam int ValueWidth = 12;
	localparam int SymbolWidth = 8;
	localparam int UcodeDepth = 13;
	localparam int PcWidth = $clog2(UcodeDepth);
	localparam logic [ValueWidth-1:0] MaxValue = ValueWidth'(3999);

	localparam logic [SymbolWidth-1:0] LetterNone = 8'h00;
	localparam logic [SymbolWidth-1:0] LetterI = 8'h49;
	localparam logic [SymbolWidth-1:0] LetterV = 8'h56;
	localparam logic [SymbolWidth-1:0] LetterX = 8'h58;
	localparam logic [SymbolWidth-1:0] LetterL = 8'h4C;
	localparam logic [SymbolWidth-1:0] LetterC = 8'h43;
	localparam logic [SymbolWidth-1:0] LetterD = 8'h44;
	localparam logic [SymbolWidth-1:0] LetterM = 8'h4D;

	// one microcode word: weight to compare and subtract, letters, pair and repeat flags
	typedef struct packed {
		logic [ValueWidth-1:0]  weight;
		logic [SymbolWidth-1:0] first;
		logic [SymbolWidth-1:0] second;
		logic                   pair;
		logic                   repeat_step;
	} ucw_t;

	localparam ucw_t UCODE [UcodeDepth] = '{
		'{ValueWidth'(1000), LetterM, LetterNone, 1'b0, 1'b1},
		'{ValueWidth'(900),  LetterC, LetterM,    1'b1, 1'b0},
		'{ValueWidth'(500),  LetterD, LetterNone, 1'b0, 1'b0},
		'{ValueWidth'(400),  LetterC, LetterD,    1'b1, 1'b0},
		'{ValueWidth'(100),  LetterC, LetterNone, 1'b0, 1'b1},
		'{ValueWidth'(90),   LetterX, LetterC,    1'b1, 1'b0},
		'{ValueWidth'(50),   LetterL, LetterNone, 1'b0, 1'b0},
		'{ValueWidth'(40),   LetterX, LetterL,    1'b1, 1'b0},
		'{ValueWidth'(10),   LetterX, LetterNone, 1'b0, 1'b1},
		'{ValueWidth'(9),    LetterI, LetterX,    1'b1, 1'b0},
		'{ValueWidth'(5),    LetterV, LetterNone, 1'b0, 1'b0},
		'{ValueWidth'(4),    LetterI, LetterV,    1'b1, 1'b0},
		'{ValueWidth'(1),    LetterI, LetterNone, 1'b0, 1'b1}
	};

	typedef struct packed {
		logic                   valid;
		logic [SymbolWidth-1:0] symbol;
		logic                   last;
		logic                   invalid;
	} emit_t;

	typedef struct packed {
		logic idle;
	} seq_status_t;

endpackage
`default_nettype wire

// ===== src/integer_to_roman_numeral.sv =====
// integer to roman numeral converter, top level with request and result handshakes
// depends on irn_pkg and irn_seq
// a legal request is accepted only while idle; the sequencer then walks the table rows from
// the largest weight down, giving a letter or moving to the next row at each step, and holds while results stall
// zero or out of range values give one invalid result the cycle after and leave the sequencer idle
// reset clears the sequencer to idle and empties the output register
`default_nettype none
module integer_to_roman_numeral (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output      logic                              req_stall,
	input  wire logic [irn_pkg::ValueWidth-1:0]    value,
	output      logic                              rsp_valid,
	input  wire logic                              rsp_stall,
	output      logic [irn_pkg::SymbolWidth-1:0]   symbol,
	output      logic                              last,
	output      logic                              invalid
);

	irn_pkg::emit_t        emit;
	irn_pkg::seq_status_t  status;
	logic                  out_free;
	logic                  acc;

	logic                              out_valid_q;
	logic [irn_pkg::SymbolWidth-1:0]   symbol_q;
	logic                              last_q;
	logic                              invalid_q;

	assign out_free = !out_valid_q || !rsp_stall;
	assign req_stall = !(status.idle && out_free);
	assign acc = req_valid && !req_stall;

	irn_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (out_free),
		.acc    (acc),
		.value  (value),
		.emit   (emit),
		.status (status)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && emit.valid) begin
			symbol_q <= emit.symbol;
			last_q <= emit.last;
			invalid_q <= emit.invalid;
		end
	end

	assign rsp_valid = out_valid_q;
	assign symbol = symbol_q;
	assign last = last_q;
	assign invalid = invalid_q;

	a_invalid_alone: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && invalid |-> last && symbol == irn_pkg::LetterNone)
		else $error("invalid result not single");

	a_letter_legal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !invalid |-> symbol == irn_pkg::LetterI || symbol == irn_pkg::LetterV
			|| symbol == irn_pkg::LetterX || symbol == irn_pkg::LetterL
			|| symbol == irn_pkg::LetterC || symbol == irn_pkg::LetterD
			|| symbol == irn_pkg::LetterM)
		else $error("illegal letter");

	a_start_run: assert property (@(posedge clk) disable iff (!arst_n)
		acc && value != '0 && value <= irn_pkg::MaxValue |=> !status.idle)
		else $error("request not started");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && last |-> status.idle)
		else $error("sequencer busy after last letter");

endmodule
`default_nettype wire

// ===== src/irn_seq.sv =====
// microcoded sequencer: step counter over the table in irn_pkg, remainder datapath
// depends on irn_pkg
`default_nettype none
module irn_seq (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              adv,
	input  wire logic                              acc,
	input  wire logic [irn_pkg::ValueWidth-1:0]    value,
	output irn_pkg::emit_t                         emit,
	output irn_pkg::seq_status_t                   status
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_PAIR = 3'b100
	} state_t;

	state_t                          state_q;
	logic [irn_pkg::PcWidth-1:0]     pc_q;
	logic [irn_pkg::ValueWidth-1:0]  rem_q;

	irn_pkg::ucw_t                   cw;
	logic                            take;
	logic [irn_pkg::ValueWidth-1:0]  diff;
	logic                            bad;

	assign cw = irn_pkg::UCODE[pc_q];
	assign take = rem_q >= cw.weight;
	assign diff = rem_q - cw.weight;
	assign bad = (value == '0) || (value > irn_pkg::MaxValue);
	assign status.idle = state_q == ST_IDLE;

	always_comb begin
		emit = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (acc && bad) begin
					emit.valid = 1'b1;
					emit.symbol = irn_pkg::LetterNone;
					emit.last = 1'b1;
					emit.invalid = 1'b1;
				end
			end
			ST_RUN: begin
				emit.valid = take;
				emit.symbol = cw.first;
				emit.last = !cw.pair && (diff == '0);
			end
			ST_PAIR: begin
				emit.valid = 1'b1;
				emit.symbol = cw.second;
				emit.last = rem_q == '0;
			end
			default: emit = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pc_q <= '0;
		end else if (adv) begin
			unique case (state_q)
				ST_IDLE: begin
					if (acc && !bad) begin
						state_q <= ST_RUN;
						pc_q <= '0;
					end
				end
				ST_RUN: begin
					if (take) begin
						if (cw.pair) begin
							state_q <= ST_PAIR;
						end else if (diff == '0) begin
							state_q <= ST_IDLE;
						end else if (!cw.repeat_step) begin
							pc_q <= pc_q + 1'b1;
						end
					end else begin
						pc_q <= pc_q + 1'b1;
					end
				end
				ST_PAIR: begin
					if (rem_q == '0) begin
						state_q <= ST_IDLE;
					end else begin
						state_q <= ST_RUN;
						pc_q <= pc_q + 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (state_q == ST_IDLE && acc) begin
				rem_q <= value;
			end else if (state_q == ST_RUN && take) begin
				rem_q <= diff;
			end
		end
	end

endmodule
`default_nettype wire

// ===== dv/tb_integer_to_roman_numeral.sv =====
// testbench for integer_to_roman_numeral: directed and random values, random idling on both
// sides, a long result hold-off, and a scoreboard that spells each numeral and checks it
// depends on irn_pkg and integer_to_roman_numeral
`timescale 1ns / 1ps
module tb_integer_to_roman_numeral;

	localparam int CycleLimit = 200000;
	localparam int HoldCycles = 200;
	localparam int DrainCycles = 40;
	localparam int IdlePercent = 38;

	class roman_scoreboard;
		typedef struct {
			logic [irn_pkg::SymbolWidth-1:0] symbol;
			logic                            last;
			logic                            invalid;
		} letter_t;

		letter_t expected_letters[$];
		int unsigned errors = 0;

		// spell the numeral one decade at a time, thousands first
		function void note_request(logic [irn_pkg::ValueWidth-1:0] v);
			logic [irn_pkg::SymbolWidth-1:0] spelled[$];
			logic [irn_pkg::SymbolWidth-1:0] one_l, five_l, ten_l;
			int unsigned dig;
			int unsigned scale;
			letter_t l;
			if (v == 0 || v > irn_pkg::MaxValue) begin
				l.symbol = irn_pkg::LetterNone;
				l.last = 1'b1;
				l.invalid = 1'b1;
				expected_letters.push_back(l);
				return;
			end
			scale = 1000;
			for (int d = 3; d >= 0; d--) begin
				dig = (v / scale) % 10;
				case (d)
					3: begin
						one_l = irn_pkg::LetterM;
						five_l = irn_pkg::LetterNone;
						ten_l = irn_pkg::LetterNone;
					end
					2: begin
						one_l = irn_pkg::LetterC;
						five_l = irn_pkg::LetterD;
						ten_l = irn_pkg::LetterM;
					end
					1: begin
						one_l = irn_pkg::LetterX;
						five_l = irn_pkg::LetterL;
						ten_l = irn_pkg::LetterC;
					end
					default: begin
						one_l = irn_pkg::LetterI;
						five_l = irn_pkg::LetterV;
						ten_l = irn_pkg::LetterX;
					end
				endcase
				if (dig == 9) begin
					spelled.push_back(one_l);
					spelled.push_back(ten_l);
				end else if (dig == 4) begin
					spelled.push_back(one_l);
					spelled.push_back(five_l);
				end else begin
					if (dig >= 5)
						spelled.push_back(five_l);
					for (int k = 0; k < int'(dig % 5); k++)
						spelled.push_back(one_l);
				end
				scale = scale / 10;
			end
			foreach (spelled[i]) begin
				l.symbol = spelled[i];
				l.last = (i == spelled.size() - 1);
				l.invalid = 1'b0;
				expected_letters.push_back(l);
			end
		endfunction

		function void check_letter(logic [irn_pkg::SymbolWidth-1:0] symbol, logic last,
			logic invalid);
			letter_t e;
			if (expected_letters.size() == 0) begin
				$display("%0t: unexpected result symbol=%h last=%b invalid=%b",
					$realtime, symbol, last, invalid);
				errors++;
				return;
			end
			e = expected_letters.pop_front();
			if (symbol !== e.symbol) begin
				$display("%0t: symbol mismatch expected %h actual %h", $realtime, e.symbol, symbol);
				errors++;
			end
			if (last !== e.last) begin
				$display("%0t: last mismatch expected %b actual %b", $realtime, e.last, last);
				errors++;
			end
			if (invalid !== e.invalid) begin
				$display("%0t: invalid mismatch expected %b actual %b",
					$realtime, e.invalid, invalid);
				errors++;
			end
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            req_valid;
	logic                            req_stall;
	logic [irn_pkg::ValueWidth-1:0]  value;
	logic                            rsp_valid;
	logic                            rsp_stall;
	logic [irn_pkg::SymbolWidth-1:0] symbol;
	logic                            last;
	logic                            invalid;

	roman_scoreboard sb = new();
	bit idle_en = 1'b1;
	bit hold_req = 1'b0;
	int unsigned hold_left = 0;
	int unsigned cycles = 0;

	integer_to_roman_numeral u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.value     (value),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.symbol    (symbol),
		.last      (last),
		.invalid   (invalid)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result side: random stalls, plus one long hold-off on request
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left == 0 && hold_req) begin
				hold_left = HoldCycles;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else
				rsp_stall <= idle_en && ($urandom_range(0, 99) < IdlePercent);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_letter(symbol, last, invalid);
	end

	task automatic send_value(input logic [irn_pkg::ValueWidth-1:0] v);
		@(negedge clk);
		while (idle_en && $urandom_range(0, 99) < IdlePercent) begin
			req_valid <= 1'b0;
			value <= irn_pkg::ValueWidth'($urandom);
			@(negedge clk);
		end
		req_valid <= 1'b1;
		value <= v;
		do
			@(posedge clk);
		while (req_stall);
		sb.note_request(v);
	endtask

	// mostly legal values, some zero and out of range
	task automatic send_random(input int unsigned n);
		int unsigned r;
		for (int unsigned i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 85)
				send_value(irn_pkg::ValueWidth'($urandom_range(1, 3999)));
			else if (r < 90)
				send_value('0);
			else
				send_value(irn_pkg::ValueWidth'($urandom_range(4000, 4095)));
		end
	endtask

	initial begin
		logic [irn_pkg::ValueWidth-1:0] directed[$];
		directed = '{1, 3999, 0, 4000, 4095, 3888, 4, 9, 40, 90, 400, 900, 49, 944,
			1994, 3, 5, 10, 50, 100, 500, 1000, 3000, 1111, 2048};
		arst_n = 1'b0;
		req_valid = 1'b0;
		value = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (directed[i])
			send_value(directed[i]);
		send_random(25);

		// stall results for a long stretch while requests keep coming
		hold_req = 1'b1;
		send_random(20);

		idle_en = 1'b0;
		send_random(20);
		idle_en = 1'b1;
		send_random(20);

		@(negedge clk);
		req_valid <= 1'b0;
		while (sb.expected_letters.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (sb.errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

// ===== files.f =====
src/irn_pkg.sv
src/irn_seq.sv
src/integer_to_roman_numeral.sv
dv/tb_integer_to_roman_numeral.sv
